/* hdl/rps_pkg.sv */
// Shared types and constants for the region pair similarity core.
package rps_pkg;

    // Field and datapath widths fixed by the item format
    localparam int BIN_W     = 16;
    localparam int COORD_W   = 12;
    localparam int LEN_W     = 13;
    localparam int PIX_W     = 25;
    localparam int EDGE_W    = 14;
    localparam int AREA_W    = 2 * EDGE_W;
    localparam int SIZES_W   = PIX_W + 1;
    localparam int WEIGHT_W  = 16;
    localparam int QUOT_W    = 16;
    localparam int SCORE_W   = 17;
    localparam int HIST_W    = 24;
    localparam int SIM_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = PIX_W;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PIXELS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_WEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_WEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_WEIGHT   = 3'd4;

    // Item operations
    typedef enum logic [1:0] {
        OP_COLOR   = 2'd0,
        OP_TEXTURE = 2'd1,
        OP_FIRST   = 2'd2,
        OP_FINISH  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  operation;
        logic [BIN_W-1:0]     bin_a;
        logic [BIN_W-1:0]     bin_b;
        logic [COORD_W-1:0]   rect_x;
        logic [COORD_W-1:0]   rect_y;
        logic [LEN_W-1:0]     rect_w;
        logic [LEN_W-1:0]     rect_h;
        logic [PIX_W-1:0]     region_size;
    } in_item_t;

    typedef struct packed {
        logic [SIM_W-1:0]     similarity;
        logic [HIST_W-1:0]    texture_similarity;
        logic [HIST_W-1:0]    color_similarity;
        logic [SCORE_W-1:0]   fill_similarity;
        logic [SCORE_W-1:0]   size_similarity;
        logic                 geometry_error;
    } out_item_t;

    // Register file contents seen by the back end
    typedef struct packed {
        logic [PIX_W-1:0]     image_pixels;
        logic [WEIGHT_W-1:0]  texture_weight;
        logic [WEIGHT_W-1:0]  fill_weight;
        logic [WEIGHT_W-1:0]  size_weight;
        logic [WEIGHT_W-1:0]  color_weight;
    } cfg_t;

    // Geometry of one finished pair, handed from front to back
    typedef struct packed {
        logic [EDGE_W-1:0]    union_w;
        logic [EDGE_W-1:0]    union_h;
        logic [SIZES_W-1:0]   sizes;
    } geom_t;

endpackage

/* hdl/region_pair_similarity_core.sv */
// Top level of the region pair similarity core: register file, front, queue, back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in       | input     | in_valid / in_stall   | in_data   (rps_pkg::in_item_t)
//  out      | output    | out_valid / out_stall | out_data  (rps_pkg::out_item_t)
//  cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Bin pairs and first-region items are absorbed by the front end; the front end never
// waits on the back end unless the finish queue is full.
// A finishing item occupies the back end through its area, check, fill, size,
// multiply-accumulate, round and emit states, mostly in the shared 16-step divider,
// run once for fill and once for size, and in a chunked 16x17 multiply-accumulate.
// Reset is asynchronous and active low; config returns to image_pixels 1 and
// all weights 1.0. A held result in the output register does not stop the
// front end or the back end from working on the next pair.
module region_pair_similarity_core #(
    parameter int MAX_DIM     = 4096,
    parameter int SUM_BITS    = 24,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rps_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rps_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rps_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import rps_pkg::*;

    localparam int JOB_W = $bits(geom_t) + 2 * SUM_BITS;

    cfg_t                cfg_reg, cfg_next;
    logic                q_full, q_empty, q_push, q_pop;
    geom_t               f_geom, b_geom;
    logic [SUM_BITS-1:0] f_tex, f_col, b_tex, b_col;
    logic [JOB_W-1:0]    q_wr, q_rd;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_PIXELS:   cfg_next.image_pixels   = cfg_data;
                REG_TEXTURE_WEIGHT: cfg_next.texture_weight = cfg_data[WEIGHT_W-1:0];
                REG_FILL_WEIGHT:    cfg_next.fill_weight    = cfg_data[WEIGHT_W-1:0];
                REG_SIZE_WEIGHT:    cfg_next.size_weight    = cfg_data[WEIGHT_W-1:0];
                REG_COLOR_WEIGHT:   cfg_next.color_weight   = cfg_data[WEIGHT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_pixels   <= PIX_W'(1);
            cfg_reg.texture_weight <= WEIGHT_W'(256);
            cfg_reg.fill_weight    <= WEIGHT_W'(256);
            cfg_reg.size_weight    <= WEIGHT_W'(256);
            cfg_reg.color_weight   <= WEIGHT_W'(256);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end
    rps_front #(
        .MAX_DIM  (MAX_DIM),
        .SUM_BITS (SUM_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (q_push),
        .job_geom (f_geom),
        .job_tex  (f_tex),
        .job_col  (f_col)
    );

    // Finish job queue
    assign q_wr = {f_geom, f_tex, f_col};

    rps_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    assign {b_geom, b_tex, b_col} = q_rd;

    // Back end
    rps_back #(
        .SUM_BITS (SUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .job_geom  (b_geom),
        .job_tex   (b_tex),
        .job_col   (b_col),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* hdl/rps_front.sv */
// Front end: accepts items, accumulates histogram intersections, forms union box.
module rps_front #(
    parameter int MAX_DIM  = 4096,
    parameter int SUM_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rps_pkg::in_item_t     in_data,
    input  logic                  q_full,
    output logic                  push,
    output rps_pkg::geom_t        job_geom,
    output logic [SUM_BITS-1:0]   job_tex,
    output logic [SUM_BITS-1:0]   job_col
);
    import rps_pkg::*;

    localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIM);

    logic [SUM_BITS-1:0] tex_sum_reg, tex_sum_next;
    logic [SUM_BITS-1:0] col_sum_reg, col_sum_next;
    logic [COORD_W-1:0]  first_left_reg, first_left_next;
    logic [COORD_W-1:0]  first_top_reg, first_top_next;
    logic [EDGE_W-1:0]   first_right_reg, first_right_next;
    logic [EDGE_W-1:0]   first_bottom_reg, first_bottom_next;
    logic [PIX_W-1:0]    first_size_reg, first_size_next;

    logic                accept;
    logic [BIN_W-1:0]    bin_min;
    logic [SUM_BITS:0]   tex_add, col_add;
    logic [EDGE_W-1:0]   right2, bottom2;
    logic [EDGE_W-1:0]   x2, y2, fl, ft;
    logic                empty1, empty2;
    logic [EDGE_W-1:0]   lo_x, lo_y, hi_x, hi_y;

    // start + length, clamped to the image dimension limit
    function automatic logic [EDGE_W-1:0] edge_end(
        input logic [COORD_W-1:0] start,
        input logic [LEN_W-1:0]   len
    );
        logic [EDGE_W-1:0] e;
        e = EDGE_W'(start) + EDGE_W'(len);
        if (32'(e) > MAX_DIM_W)
        begin
            e = EDGE_W'(MAX_DIM);
        end
        return e;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && (in_data.operation == OP_FINISH);

    // Histogram intersection terms, saturating
    assign bin_min = (in_data.bin_a < in_data.bin_b) ? in_data.bin_a : in_data.bin_b;
    assign tex_add = {1'b0, tex_sum_reg} + (SUM_BITS+1)'(bin_min);
    assign col_add = {1'b0, col_sum_reg} + (SUM_BITS+1)'(bin_min);

    // Union box of stored first region and incoming second region
    assign x2      = EDGE_W'(in_data.rect_x);
    assign y2      = EDGE_W'(in_data.rect_y);
    assign fl      = EDGE_W'(first_left_reg);
    assign ft      = EDGE_W'(first_top_reg);
    assign right2  = edge_end(in_data.rect_x, in_data.rect_w);
    assign bottom2 = edge_end(in_data.rect_y, in_data.rect_h);
    assign empty1  = (first_right_reg <= fl) || (first_bottom_reg <= ft);
    assign empty2  = (right2 <= x2) || (bottom2 <= y2);
    assign lo_x    = (fl < x2) ? fl : x2;
    assign lo_y    = (ft < y2) ? ft : y2;
    assign hi_x    = (first_right_reg > right2) ? first_right_reg : right2;
    assign hi_y    = (first_bottom_reg > bottom2) ? first_bottom_reg : bottom2;

    always_comb
    begin
        priority if (empty1 && empty2)
        begin
            job_geom.union_w = '0;
            job_geom.union_h = '0;
        end
        else if (empty1)
        begin
            job_geom.union_w = right2 - x2;
            job_geom.union_h = bottom2 - y2;
        end
        else if (empty2)
        begin
            job_geom.union_w = first_right_reg - fl;
            job_geom.union_h = first_bottom_reg - ft;
        end
        else
        begin
            job_geom.union_w = hi_x - lo_x;
            job_geom.union_h = hi_y - lo_y;
        end
        job_geom.sizes = SIZES_W'(first_size_reg) + SIZES_W'(in_data.region_size);
    end

    assign job_tex = tex_sum_reg;
    assign job_col = col_sum_reg;

    // State update per accepted item
    always_comb
    begin
        tex_sum_next      = tex_sum_reg;
        col_sum_next      = col_sum_reg;
        first_left_next   = first_left_reg;
        first_top_next    = first_top_reg;
        first_right_next  = first_right_reg;
        first_bottom_next = first_bottom_reg;
        first_size_next   = first_size_reg;
        if (accept)
        begin
            unique case (in_data.operation)
                OP_COLOR:
                begin
                    col_sum_next = col_add[SUM_BITS] ? '1 : col_add[SUM_BITS-1:0];
                end
                OP_TEXTURE:
                begin
                    tex_sum_next = tex_add[SUM_BITS] ? '1 : tex_add[SUM_BITS-1:0];
                end
                OP_FIRST:
                begin
                    first_left_next   = in_data.rect_x;
                    first_top_next    = in_data.rect_y;
                    first_right_next  = right2;
                    first_bottom_next = bottom2;
                    first_size_next   = in_data.region_size;
                end
                OP_FINISH:
                begin
                    tex_sum_next = '0;
                    col_sum_next = '0;
                end
                default:
                begin
                    tex_sum_next = tex_sum_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_sum_reg      <= '0;
            col_sum_reg      <= '0;
            first_left_reg   <= '0;
            first_top_reg    <= '0;
            first_right_reg  <= '0;
            first_bottom_reg <= '0;
            first_size_reg   <= '0;
        end
        else
        begin
            tex_sum_reg      <= tex_sum_next;
            col_sum_reg      <= col_sum_next;
            first_left_reg   <= first_left_next;
            first_top_reg    <= first_top_next;
            first_right_reg  <= first_right_next;
            first_bottom_reg <= first_bottom_next;
            first_size_reg   <= first_size_next;
        end
    end

endmodule

/* hdl/rps_queue.sv */
// Short register queue of finish jobs between front end and back end.
module rps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import rps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/rps_div.sv */
// Radix-2 divider for round(num * 2^16 / den) with num < den.
module rps_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rps_pkg::PIX_W-1:0]    num,
    input  logic [rps_pkg::PIX_W-1:0]    den,
    output logic                         done,
    output logic [rps_pkg::QUOT_W:0]     quot
);
    import rps_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PIX_W-1:0]    rem_reg, rem_next;
    logic [PIX_W-1:0]    den_reg, den_next;
    // one extra bit: rounding up from all ones gives exactly 2^16
    logic [QUOT_W:0]     quot_reg, quot_next;
    logic [PIX_W:0]      trial;
    logic [PIX_W:0]      rnd_sum;

    assign trial   = {rem_reg, 1'b0};
    assign rnd_sum = {1'b0, rem_reg} + {2'b00, den_reg[PIX_W-1:1]};

    // One quotient bit per cycle, then a half-divisor rounding correction
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_W);
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next  = PIX_W'(trial - {1'b0, den_reg});
                    quot_next = {1'b0, quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[PIX_W-1:0];
                    quot_next = {1'b0, quot_reg[QUOT_W-2:0], 1'b0};
                end
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (rnd_sum >= {1'b0, den_reg})
                begin
                    quot_next = quot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hdl/rps_back.sv */
// Back end: area, fill and size scores, weighted sum and result register.
module rps_back #(
    parameter int SUM_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rps_pkg::cfg_t         cfg,
    input  logic                  q_empty,
    output logic                  pop,
    input  rps_pkg::geom_t        job_geom,
    input  logic [SUM_BITS-1:0]   job_tex,
    input  logic [SUM_BITS-1:0]   job_col,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rps_pkg::out_item_t    out_data
);
    import rps_pkg::*;

    localparam int NCH    = (SUM_BITS + 15) / 16;
    localparam int PAD_W  = NCH * 16;
    localparam int NSTEP  = 2 * NCH + 2;
    localparam int STEP_W = $clog2(NSTEP + 1);
    localparam int SH_W   = $clog2(PAD_W);
    localparam int PROD_W = WEIGHT_W + SCORE_W;
    localparam int TOT_W  = SUM_BITS + 18;
    localparam int RND_W  = TOT_W - 8;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_AREA  = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_FILL  = 8'b0000_1000,
        S_SIZE  = 8'b0001_0000,
        S_MAC   = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    geom_t                geom_reg, geom_next;
    logic [SUM_BITS-1:0]  tex_reg, tex_next;
    logic [SUM_BITS-1:0]  col_reg, col_next;
    logic [AREA_W-1:0]    area_reg, area_next;
    logic                 err_reg, err_next;
    logic                 fill_over_reg, fill_over_next;
    logic                 fill_zero_reg, fill_zero_next;
    logic                 size_zero_reg, size_zero_next;
    logic [SCORE_W-1:0]   fill_reg, fill_next;
    logic [SCORE_W-1:0]   size_reg, size_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 prod_vld_reg, prod_vld_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [SH_W-1:0]      shift_reg, shift_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;

    logic [PIX_W-1:0]     pix;
    logic [AREA_W-1:0]    sizes_ext;
    logic [AREA_W-1:0]    pix_ext;
    logic [AREA_W-1:0]    empty_area;
    logic                 over_area, over_pix, empty_big;
    logic                 div_start, div_done;
    logic [PIX_W-1:0]     div_num;
    logic [QUOT_W:0]      div_quot;
    logic [SCORE_W-1:0]   div_score;

    logic [PAD_W-1:0]     tex_pad, col_pad;
    logic [STEP_W-1:0]    chunk;
    logic [WEIGHT_W-1:0]  mac_w;
    logic [SCORE_W-1:0]   mac_op;
    logic [SH_W-1:0]      mac_sh;

    logic [HIST_W+SUM_BITS-1:0] tex_wide, col_wide;
    logic [SIM_W+RND_W-1:0]     sim_wide;

    // Divisor and geometry checks
    assign pix        = (cfg.image_pixels == '0) ? PIX_W'(1) : cfg.image_pixels;
    assign sizes_ext  = AREA_W'(geom_reg.sizes);
    assign pix_ext    = AREA_W'(pix);
    assign over_area  = sizes_ext > area_reg;
    assign over_pix   = sizes_ext > pix_ext;
    assign empty_area = area_reg - sizes_ext;
    assign empty_big  = empty_area >= pix_ext;
    assign div_score  = SCORE_ONE - SCORE_W'(div_quot);

    rps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (pix),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Weight and operand for the current multiply step
    assign tex_pad = PAD_W'(tex_reg);
    assign col_pad = PAD_W'(col_reg);

    always_comb
    begin
        chunk  = '0;
        mac_w  = cfg.size_weight;
        mac_op = size_reg;
        mac_sh = '0;
        if (step_reg < STEP_W'(NCH))
        begin
            chunk  = step_reg;
            mac_w  = cfg.texture_weight;
            mac_op = SCORE_W'(16'(tex_pad >> (16 * chunk)));
            mac_sh = SH_W'(chunk) << 4;
        end
        else if (step_reg < STEP_W'(2 * NCH))
        begin
            chunk  = step_reg - STEP_W'(NCH);
            mac_w  = cfg.color_weight;
            mac_op = SCORE_W'(16'(col_pad >> (16 * chunk)));
            mac_sh = SH_W'(chunk) << 4;
        end
        else if (step_reg == STEP_W'(2 * NCH))
        begin
            mac_w  = cfg.fill_weight;
            mac_op = fill_reg;
        end
    end

    // Output saturation
    assign tex_wide = {{HIST_W{1'b0}}, tex_reg};
    assign col_wide = {{HIST_W{1'b0}}, col_reg};
    assign sim_wide = {{SIM_W{1'b0}}, rnd_reg};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        geom_next      = geom_reg;
        tex_next       = tex_reg;
        col_next       = col_reg;
        area_next      = area_reg;
        err_next       = err_reg;
        fill_over_next = fill_over_reg;
        fill_zero_next = fill_zero_reg;
        size_zero_next = size_zero_reg;
        fill_next      = fill_reg;
        size_next      = size_reg;
        step_next      = step_reg;
        prod_vld_next  = prod_vld_reg;
        prod_next      = prod_reg;
        shift_next     = shift_reg;
        total_next     = total_reg;
        rnd_next       = rnd_reg;
        pop            = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    geom_next  = job_geom;
                    tex_next   = job_tex;
                    col_next   = job_col;
                    state_next = S_AREA;
                end
            end
            S_AREA:
            begin
                area_next  = geom_reg.union_w * geom_reg.union_h;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                err_next       = over_area || over_pix;
                fill_over_next = over_area;
                fill_zero_next = empty_big;
                div_start      = 1'b1;
                div_num        = (over_area || empty_big) ? '0 : empty_area[PIX_W-1:0];
                state_next     = S_FILL;
            end
            S_FILL:
            begin
                if (div_done)
                begin
                    priority if (fill_over_reg)
                    begin
                        fill_next = SCORE_ONE;
                    end
                    else if (fill_zero_reg)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = div_score;
                    end
                    size_zero_next = sizes_ext >= pix_ext;
                    div_start      = 1'b1;
                    div_num        = (sizes_ext >= pix_ext) ? '0 : geom_reg.sizes[PIX_W-1:0];
                    state_next     = S_SIZE;
                end
            end
            S_SIZE:
            begin
                if (div_done)
                begin
                    size_next     = size_zero_reg ? '0 : div_score;
                    step_next     = '0;
                    prod_vld_next = 1'b0;
                    total_next    = '0;
                    state_next    = S_MAC;
                end
            end
            S_MAC:
            begin
                // multiply into the product register, add the shifted product in the next cycle
                if (prod_vld_reg)
                begin
                    total_next = total_reg + (TOT_W'(prod_reg) << shift_reg);
                end
                if (step_reg < STEP_W'(NSTEP))
                begin
                    prod_next     = PROD_W'(mac_w * mac_op);
                    shift_next    = mac_sh;
                    prod_vld_next = 1'b1;
                    step_next     = step_reg + 1'b1;
                end
                else
                begin
                    prod_vld_next = 1'b0;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                rnd_next   = RND_W'((total_reg + TOT_W'(128)) >> 8);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.similarity = (sim_wide[SIM_W+RND_W-1:SIM_W] != '0)
                                             ? '1 : sim_wide[SIM_W-1:0];
                    out_data_next.texture_similarity =
                        (tex_wide[HIST_W+SUM_BITS-1:HIST_W] != '0) ? '1 : tex_wide[HIST_W-1:0];
                    out_data_next.color_similarity =
                        (col_wide[HIST_W+SUM_BITS-1:HIST_W] != '0) ? '1 : col_wide[HIST_W-1:0];
                    out_data_next.fill_similarity = fill_reg;
                    out_data_next.size_similarity = size_reg;
                    out_data_next.geometry_error  = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            prod_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            prod_vld_reg  <= prod_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        geom_reg      <= geom_next;
        tex_reg       <= tex_next;
        col_reg       <= col_next;
        area_reg      <= area_next;
        err_reg       <= err_next;
        fill_over_reg <= fill_over_next;
        fill_zero_reg <= fill_zero_next;
        size_zero_reg <= size_zero_next;
        fill_reg      <= fill_next;
        size_reg      <= size_next;
        prod_reg      <= prod_next;
        shift_reg     <= shift_next;
        total_reg     <= total_next;
        rnd_reg       <= rnd_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* dv/region_pair_similarity_core_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for region_pair_similarity_core: directed table, then random pairs.
module region_pair_similarity_core_test;
    import rps_pkg::*;

    localparam int MAX_DIM  = 4096;
    localparam int SUM_BITS = 24;

    localparam longint unsigned SUM_MAX  = (64'd1 << SUM_BITS) - 1;
    localparam longint unsigned HIST_MAX = 64'hFF_FFFF;
    localparam longint unsigned SIM_MAX  = 64'hFFFF_FFFF;
    localparam longint unsigned Q16_ONE  = 64'd65536;
    localparam int unsigned     PIX_MAX  = 1 << 24;
    localparam int unsigned     XY_MAX   = (1 << COORD_W) - 1;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int DIR_ROWS        = 24;
    // margin after the last result before the configuration is rewritten
    localparam int CFG_PAUSE       = 100;
    localparam int DRAIN_CYCLES    = 100;
    // far above any legal quiet stretch: queue full of finishes behind a long stall
    localparam int WATCHDOG_LIMIT  = 4000;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // predictor state: configuration, histogram sums, stored first region
    cfg_t            model_cfg;
    longint unsigned color_acc;
    longint unsigned texture_acc;
    longint unsigned first_l, first_t, first_r, first_b, first_px;

    out_item_t expected_scores[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        idle_pct   = 0;
    int        stall_pct  = 0;

    int idle_by_phase  [PHASES] = '{0, 80, 0, 30, 0, 30};
    int stall_by_phase [PHASES] = '{0, 0, 80, 30, 0, 30};

    dir_row_t directed_rows [DIR_ROWS];

    region_pair_similarity_core #(
        .MAX_DIM  (MAX_DIM),
        .SUM_BITS (SUM_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint unsigned sat_sum(input longint unsigned acc,
                                                input longint unsigned v);
        return (acc + v > SUM_MAX) ? SUM_MAX : acc + v;
    endfunction

    function automatic longint unsigned edge_limit(input longint unsigned start,
                                                   input longint unsigned len);
        return (start + len > MAX_DIM) ? MAX_DIM : start + len;
    endfunction

    // 1.0 minus v/p in Q16, ratio rounded half up, floored at zero
    function automatic longint unsigned ratio_score(input longint unsigned v,
                                                    input longint unsigned p);
        longint unsigned q;
        q = (v * Q16_ONE + p / 2) / p;
        return (q >= Q16_ONE) ? 0 : Q16_ONE - q;
    endfunction

    // Advance the model by one item; returns 1 when the item closes a pair
    function automatic bit score_item(input in_item_t it, output out_item_t res);
        longint unsigned m, x, y, r2, b2, area, sizes, p, fill, size_s, total;
        bit              e1, e2, err;
        res = '0;
        m = (it.bin_a < it.bin_b) ? it.bin_a : it.bin_b;
        x = it.rect_x;
        y = it.rect_y;
        if (it.operation == OP_COLOR) begin
            color_acc = sat_sum(color_acc, m);
            return 1'b0;
        end
        if (it.operation == OP_TEXTURE) begin
            texture_acc = sat_sum(texture_acc, m);
            return 1'b0;
        end
        if (it.operation == OP_FIRST) begin
            first_l  = x;
            first_t  = y;
            first_r  = edge_limit(x, it.rect_w);
            first_b  = edge_limit(y, it.rect_h);
            first_px = it.region_size;
            return 1'b0;
        end

        // finish: union box of the two regions, an empty box drops out
        r2 = edge_limit(x, it.rect_w);
        b2 = edge_limit(y, it.rect_h);
        e1 = (first_r <= first_l) || (first_b <= first_t);
        e2 = (r2 <= x) || (b2 <= y);
        if (e1 && e2)
            area = 0;
        else if (e1)
            area = (r2 - x) * (b2 - y);
        else if (e2)
            area = (first_r - first_l) * (first_b - first_t);
        else
            area = ((first_r > r2 ? first_r : r2) - (first_l < x ? first_l : x))
                 * ((first_b > b2 ? first_b : b2) - (first_t < y ? first_t : y));

        sizes = first_px + it.region_size;
        p     = (model_cfg.image_pixels == 0) ? 1 : model_cfg.image_pixels;
        err   = 1'b0;
        if (sizes > area) begin
            fill = Q16_ONE;
            err  = 1'b1;
        end
        else begin
            fill = ratio_score(area - sizes, p);
        end
        if (sizes > p) begin
            size_s = 0;
            err    = 1'b1;
        end
        else begin
            size_s = ratio_score(sizes, p);
        end

        // Q18.24 total, rounded half up to Q16.16
        total = model_cfg.texture_weight * texture_acc + model_cfg.color_weight * color_acc
              + model_cfg.fill_weight * fill + model_cfg.size_weight * size_s;
        total = (total + 128) >> 8;
        if (total > SIM_MAX)
            total = SIM_MAX;

        res.similarity         = total[SIM_W-1:0];
        res.texture_similarity = (texture_acc > HIST_MAX) ? HIST_MAX : texture_acc;
        res.color_similarity   = (color_acc > HIST_MAX) ? HIST_MAX : color_acc;
        res.fill_similarity    = fill[SCORE_W-1:0];
        res.size_similarity    = size_s[SCORE_W-1:0];
        res.geometry_error     = err;
        color_acc   = 0;
        texture_acc = 0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- random fields

    function automatic logic [BIN_W-1:0] rand_bin();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return XY_MAX;
            default: return $urandom_range(0, XY_MAX);
        endcase
    endfunction

    // mostly modest boxes so that unions and sizes stay comparable
    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(7))
            0:       return '0;
            1:       return MAX_DIM;
            2:       return $urandom_range(0, MAX_DIM);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic in_item_t random_item(input op_t op);
        in_item_t    it;
        int unsigned box;
        it.operation = op;
        it.bin_a     = rand_bin();
        it.bin_b     = rand_bin();
        it.rect_x    = rand_coord();
        it.rect_y    = rand_coord();
        it.rect_w    = rand_len();
        it.rect_h    = rand_len();
        box          = 32'(it.rect_w) * 32'(it.rect_h);
        case ($urandom_range(3))
            0:       it.region_size = $urandom_range(0, box);
            1:       it.region_size = box;
            2:       it.region_size = $urandom_range(0, PIX_MAX);
            default: it.region_size = $urandom_range(0, 100);
        endcase
        return it;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Present one item, hold it through stalls, record what it should produce
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t res;
        bit        produced;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        produced = score_item(it, res);
        if (typed)
            expected_scores.push_back(want);
        else if (produced)
            expected_scores.push_back(res);
        items_sent++;
    endtask

    // One region pair: bins, first geometry, finish; some noise and broken pairs
    task automatic send_sequence(input bit long_run);
        in_item_t it;
        int       nbins;
        if (!long_run && $urandom_range(99) < 10) begin
            send_item(random_item(op_t'($urandom_range(3))), 1'b0, '0);
        end
        else begin
            // a long run of high bins builds large sums
            nbins = long_run ? $urandom_range(257, 264) : $urandom_range(0, 12);
            for (int i = 0; i < nbins; i++) begin
                it = random_item($urandom_range(1) ? OP_TEXTURE : OP_COLOR);
                if (long_run) begin
                    it.bin_a = $urandom_range(16'hF000, 16'hFFFF);
                    it.bin_b = $urandom_range(16'hF000, 16'hFFFF);
                end
                send_item(it, 1'b0, '0);
            end
            if ($urandom_range(9) != 0)
                send_item(random_item(OP_FIRST), 1'b0, '0);
            if ($urandom_range(19) != 0)
                send_item(random_item(OP_FINISH), 1'b0, '0);
        end
    endtask

    // Caller lowers cfg_valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_IMAGE_PIXELS:   model_cfg.image_pixels   = value;
            REG_TEXTURE_WEIGHT: model_cfg.texture_weight = value[WEIGHT_W-1:0];
            REG_FILL_WEIGHT:    model_cfg.fill_weight    = value[WEIGHT_W-1:0];
            REG_SIZE_WEIGHT:    model_cfg.size_weight    = value[WEIGHT_W-1:0];
            REG_COLOR_WEIGHT:   model_cfg.color_weight   = value[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(REG_IMAGE_PIXELS,   c.image_pixels);
        write_reg(REG_TEXTURE_WEIGHT, CFG_DAT_W'(c.texture_weight));
        write_reg(REG_FILL_WEIGHT,    CFG_DAT_W'(c.fill_weight));
        write_reg(REG_SIZE_WEIGHT,    CFG_DAT_W'(c.size_weight));
        write_reg(REG_COLOR_WEIGHT,   CFG_DAT_W'(c.color_weight));
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- result check

    function automatic void check_field(input string name, input longint unsigned want_v,
                                        input longint unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // compare each accepted result with the oldest expectation, then pick a stall
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_scores.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, out_data);
                mismatches++;
            end
            else begin
                want = expected_scores.pop_front();
                check_field("similarity", want.similarity, out_data.similarity);
                check_field("texture_similarity", want.texture_similarity,
                            out_data.texture_similarity);
                check_field("color_similarity", want.color_similarity,
                            out_data.color_similarity);
                check_field("fill_similarity", want.fill_similarity,
                            out_data.fill_similarity);
                check_field("size_similarity", want.size_similarity,
                            out_data.size_similarity);
                check_field("geometry_error", want.geometry_error, out_data.geometry_error);
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ---------------------------------------------------------------- watchdog

    initial begin
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("region_pair_similarity_core: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        cfg_t phase_cfg;
        int   phase_end;
        bit   first_seq;

        // reset values of the model
        model_cfg   = '{1, 256, 256, 256, 256};
        color_acc   = 0;
        texture_acc = 0;
        first_l     = 0;
        first_t     = 0;
        first_r     = 0;
        first_b     = 0;
        first_px    = 0;

        // Directed table, run at reset config (one pixel, weights 1.0).
        // Expectations are typed in where they follow directly from the reset state.
        directed_rows = '{
            // all-zero pair straight after reset: both boxes empty
            '{'{OP_FINISH, 0, 0, 0, 0, 0, 0, 0}, 1, '{131072, 0, 0, 65536, 65536, 0}},
            // full-scale bins, min of a and b
            '{'{OP_COLOR, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 0}, 0, '0},
            '{'{OP_TEXTURE, 'hFFFF, 0, 0, 0, 0, 0, 0}, 0, '0},
            '{'{OP_TEXTURE, 0, 'hFFFF, 0, 0, 0, 0, 0}, 0, '0},
            '{'{OP_TEXTURE, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 0}, 0, '0},
            // edges clamp at the image border; sizes over area and image pixels
            '{'{OP_FINISH, 0, 0, 4095, 4095, 4096, 4096, 2}, 1,
              '{196606, 65535, 65535, 65536, 0, 1}},
            // full-image first region, empty second box
            '{'{OP_FIRST, 0, 0, 0, 0, 4096, 4096, 'h100_0000}, 0, '0},
            '{'{OP_FINISH, 0, 0, 4095, 4095, 0, 0, 0}, 1, '{65536, 0, 0, 65536, 0, 1}},
            // first region is kept after a finish
            '{'{OP_FINISH, 0, 0, 0, 0, 1, 1, 0}, 0, '0},
            // alternating bit patterns
            '{'{OP_COLOR, 'h1234, 'hABCD, 0, 0, 0, 0, 0}, 0, '0},
            '{'{OP_COLOR, 'hAAAA, 'h5555, 0, 0, 0, 0, 0}, 0, '0},
            '{'{OP_TEXTURE, 'h5555, 'hAAAA, 0, 0, 0, 0, 0}, 0, '0},
            '{'{OP_FIRST, 'hAAAA, 'h5555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAA_AAAA}, 0, '0},
            '{'{OP_FINISH, 'h5555, 'hAAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h55_5555}, 0, '0},
            // empty first box: union is the second box
            '{'{OP_FIRST, 0, 0, 100, 100, 0, 50, 0}, 0, '0},
            '{'{OP_FINISH, 0, 0, 10, 10, 20, 20, 400}, 0, '0},
            // clamped first box far from the second
            '{'{OP_FIRST, 0, 0, 4000, 4000, 4096, 4096, 9216}, 0, '0},
            '{'{OP_FINISH, 0, 0, 0, 0, 10, 10, 100}, 0, '0},
            // two empty boxes with zero sizes
            '{'{OP_FIRST, 0, 0, 5, 5, 10, 0, 0}, 0, '0},
            '{'{OP_FINISH, 0, 0, 7, 7, 0, 3, 0}, 1, '{131072, 0, 0, 65536, 65536, 0}},
            // overlapping boxes, sizes above union area
            '{'{OP_FIRST, 0, 0, 0, 0, 2, 2, 3}, 0, '0},
            '{'{OP_FINISH, 0, 0, 1, 1, 2, 2, 7}, 1, '{65536, 0, 0, 65536, 0, 1}},
            // empty area above image pixels: fill clamps to zero, no error
            '{'{OP_FIRST, 0, 0, 0, 0, 4096, 4096, 0}, 0, '0},
            '{'{OP_FINISH, 0, 0, 0, 0, 0, 0, 1}, 1, '{0, 0, 0, 0, 0, 0}}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            if (ph == 0) begin
                foreach (directed_rows[i])
                    send_item(directed_rows[i].item, directed_rows[i].typed,
                              directed_rows[i].want);
            end
            else begin
                // registers change only with the core drained
                in_valid <= 1'b0;
                while (expected_scores.size() != 0)
                    @(posedge clk);
                repeat (CFG_PAUSE) @(posedge clk);
                case (ph)
                    1:       phase_cfg = '{PIX_MAX, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF};
                    2:       phase_cfg = '{0, 0, 0, 0, 0};
                    3:       phase_cfg = '{307200, 256, 512, 128, 1024};
                    4:       phase_cfg = '{$urandom_range(1, 4096), $urandom_range(0, 'hFFFF),
                                           $urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF),
                                           $urandom_range(0, 'hFFFF)};
                    default: phase_cfg = '{$urandom_range(1, PIX_MAX), $urandom_range(0, 'hFFFF),
                                           $urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF),
                                           $urandom_range(0, 'hFFFF)};
                endcase
                load_config(phase_cfg);
            end

            // random pairs; max weights and the last phase open with a long run of high bins
            phase_end = items_sent + ITEMS_PER_PHASE;
            first_seq = 1'b1;
            while (items_sent < phase_end) begin
                send_sequence((first_seq && (ph == 1 || ph == 5)) || $urandom_range(79) == 0);
                first_seq = 1'b0;
            end
        end

        in_valid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("region_pair_similarity_core: match");
        else
            $display("region_pair_similarity_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rps_pkg.sv
hdl/rps_front.sv
hdl/rps_queue.sv
hdl/rps_div.sv
hdl/rps_back.sv
hdl/region_pair_similarity_core.sv
dv/region_pair_similarity_core_test.sv
